/* hdl/sovf_pkg.sv */
`timescale 1ns / 1ps

package sovf_pkg;

    // Field and datapath widths.
    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 32;
    localparam int STATE_W  = 48;
    localparam int SUM_W    = 50;
    localparam int X_W      = 52;
    localparam int COEF_W   = 32;
    localparam int PART_W   = 26;
    localparam int PROD_W   = 84;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Number of microcode steps for one integration step.
    localparam int N_OPS  = 18;
    localparam int STEP_W = 5;

    // Nibbles handled by the divide-by-six unit.
    localparam int DIV_DIGITS = 13;

    localparam logic signed [STATE_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [STATE_W-1:0] MIN48 = 48'sh8000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NATURAL_FREQ_A = 3'd0,
        REG_DAMPING_A      = 3'd1,
        REG_NATURAL_FREQ_B = 3'd2,
        REG_DAMPING_B      = 3'd3,
        REG_STEP_PERIOD    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic                       gain_select;
        logic                       restart;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          out_channel;
        logic signed [SAMPLE_W-1:0] position_estimate;
        logic signed [SAMPLE_W-1:0] velocity_estimate;
    } result_t;

    // One channel's stored state.
    typedef struct packed {
        logic signed [STATE_W-1:0]  position;
        logic signed [STATE_W-1:0]  velocity;
        logic signed [SAMPLE_W-1:0] previous;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE,
        ST_MUL,
        ST_POST,
        ST_DIV,
        ST_WB,
        ST_STORE
    } state_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LOW,
        MP_HIGH,
        MP_SUM
    } mul_phase_t;

    // Multiplier coefficient selection.
    typedef enum logic [1:0] {
        CF_WN,
        CF_W2,
        CF_C,
        CF_T
    } coef_sel_t;

    // Multiplier operand selection.
    typedef enum logic [3:0] {
        XS_WN,
        XS_ZT,
        XS_U0_P0,
        XS_UM_PP,
        XS_U1_PP,
        XS_KV,
        XS_KA,
        XS_SP,
        XS_SV
    } xsrc_t;

    // Scaling of the raw product.
    typedef enum logic [2:0] {
        SC_RAW,
        SC_GAIN,
        SC_HALF,
        SC_FULL,
        SC_SIXTH
    } scale_t;

    // Where the scaled result is written back.
    typedef enum logic [2:0] {
        DS_W2,
        DS_C,
        DS_A1,
        DS_KA,
        DS_PP,
        DS_KV,
        DS_P0,
        DS_V0
    } dest_t;

    typedef struct packed {
        coef_sel_t coef;
        xsrc_t     xsrc;
        scale_t    scale;
        dest_t     dest;
    } op_t;

    // Microcode: gain products, then the four Runge-Kutta stages, then the update.
    function automatic op_t op_at(input logic [STEP_W-1:0] step);
        op_t op;
        unique case (step)
            5'd0:    op = '{CF_WN, XS_WN,    SC_RAW,   DS_W2};
            5'd1:    op = '{CF_WN, XS_ZT,    SC_RAW,   DS_C};
            5'd2:    op = '{CF_W2, XS_U0_P0, SC_GAIN,  DS_A1};
            5'd3:    op = '{CF_C,  XS_KV,    SC_GAIN,  DS_KA};
            5'd4:    op = '{CF_T,  XS_KV,    SC_HALF,  DS_PP};
            5'd5:    op = '{CF_T,  XS_KA,    SC_HALF,  DS_KV};
            5'd6:    op = '{CF_W2, XS_UM_PP, SC_GAIN,  DS_A1};
            5'd7:    op = '{CF_C,  XS_KV,    SC_GAIN,  DS_KA};
            5'd8:    op = '{CF_T,  XS_KV,    SC_HALF,  DS_PP};
            5'd9:    op = '{CF_T,  XS_KA,    SC_HALF,  DS_KV};
            5'd10:   op = '{CF_W2, XS_UM_PP, SC_GAIN,  DS_A1};
            5'd11:   op = '{CF_C,  XS_KV,    SC_GAIN,  DS_KA};
            5'd12:   op = '{CF_T,  XS_KV,    SC_FULL,  DS_PP};
            5'd13:   op = '{CF_T,  XS_KA,    SC_FULL,  DS_KV};
            5'd14:   op = '{CF_W2, XS_U1_PP, SC_GAIN,  DS_A1};
            5'd15:   op = '{CF_C,  XS_KV,    SC_GAIN,  DS_KA};
            5'd16:   op = '{CF_T,  XS_SP,    SC_SIXTH, DS_P0};
            5'd17:   op = '{CF_T,  XS_SV,    SC_SIXTH, DS_V0};
            default: op = '{CF_WN, XS_WN,    SC_RAW,   DS_W2};
        endcase
        return op;
    endfunction

endpackage

/* hdl/sovf_mul.sv */
`timescale 1ns / 1ps

module sovf_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sovf_pkg::COEF_W-1:0]    coef,
    input  logic [sovf_pkg::X_W-1:0]       mag,
    output logic                           done,
    output logic [sovf_pkg::PROD_W-1:0]    product
);
    import sovf_pkg::*;

    localparam int PP_W = COEF_W + PART_W;

    mul_phase_t           phase_reg;
    mul_phase_t           phase_next;
    logic                 done_reg;
    logic [COEF_W-1:0]    coef_reg;
    logic [X_W-1:0]       mag_reg;
    logic [PP_W-1:0]      lo_reg;
    logic [PP_W-1:0]      hi_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [PART_W-1:0]    operand;
    logic [PP_W-1:0]      partial;

    // The single multiplier takes the low half, then the high half.
    assign operand = (phase_reg == MP_LOW) ? mag_reg[PART_W-1:0] : mag_reg[X_W-1:PART_W];
    assign partial = PP_W'(coef_reg) * PP_W'(operand);

    always_comb
    begin
        unique case (phase_reg)
            MP_IDLE: phase_next = start ? MP_LOW : MP_IDLE;
            MP_LOW:  phase_next = MP_HIGH;
            MP_HIGH: phase_next = MP_SUM;
            MP_SUM:  phase_next = MP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_SUM);
        end
    end

    // Operand capture and partial products.
    always_ff @(posedge clk)
    begin
        if (phase_reg == MP_IDLE && start)
        begin
            coef_reg <= coef;
            mag_reg  <= mag;
        end
        if (phase_reg == MP_LOW)
        begin
            lo_reg <= partial;
        end
        if (phase_reg == MP_HIGH)
        begin
            hi_reg <= partial;
        end
        if (phase_reg == MP_SUM)
        begin
            product_reg <= (PROD_W'(hi_reg) << PART_W) + PROD_W'(lo_reg);
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

/* hdl/sovf_div6.sv */
`timescale 1ns / 1ps

module sovf_div6 (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sovf_pkg::X_W-1:0]  dividend,
    output logic                      done,
    output logic [sovf_pkg::X_W-1:0]  quotient
);
    import sovf_pkg::*;

    localparam int CNT_W = $clog2(DIV_DIGITS + 1);

    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [X_W-1:0]   num_reg;
    logic [X_W-1:0]   quot_reg;
    logic [2:0]       rem_reg;
    logic [6:0]       val;
    logic [12:0]      recip;
    logic [3:0]       qdig;
    logic [6:0]       qsix;
    logic [2:0]       rem_next;

    // One nibble per cycle: the partial value stays below 96, where
    // multiplying by 43/256 gives the exact quotient by six.
    assign val      = {rem_reg, num_reg[X_W-1 -: 4]};
    assign recip    = 13'(val) * 13'd43;
    assign qdig     = recip[11:8];
    assign qsix     = 7'(qdig) * 7'd6;
    assign rem_next = 3'(val - qsix);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_DIGITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 4;
            quot_reg <= {quot_reg[X_W-5:0], qdig};
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* hdl/second_order_velocity_filter_core.sv */
`timescale 1ns / 1ps

// Second-order smoothing filter with velocity estimate, several channels.
// Item channel: item_valid/item_ready carry one sample request for one channel.
// Result channel: result_valid/result_ready return the filtered position and
// velocity for that request, one result per request, in order.
// Config channel: cfg_valid/cfg_ready write one register by cfg_index; always
// ready; the user must write it only while the block is idle, which the block does not enforce.
// A seeding request (first sample of a channel, or restart set) passes from
// acceptance through the load and store states to its result. An integration
// request runs 18 microcode steps on one shared 32x26 multiplier plus two
// serial divides by six. The block takes one request at a time; item_ready is
// high only while idle, so the shared multiplier sets the throughput.
// The result waits in an output register; a stalled receiver holds the next
// request's result back only at its final store, the filter state stays intact.
// Reset restores the register defaults and marks every channel unseeded.
module second_order_velocity_filter_core #(
    parameter int CHANNELS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  sovf_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output sovf_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sovf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sovf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sovf_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_L = 7'(CHANNELS);
    localparam logic signed [52:0] MAX48_W = 53'(MAX48);
    localparam logic signed [52:0] MIN48_W = 53'(MIN48);
    localparam logic signed [47:0] MAX32_W = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] MIN32_W = -48'sh0000_8000_0000;

    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [52:0] x);
        logic signed [STATE_W-1:0] y;
        if (x > MAX48_W)
            y = MAX48;
        else if (x < MIN48_W)
            y = MIN48;
        else
            y = STATE_W'(x);
        return y;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [47:0] x);
        logic signed [SAMPLE_W-1:0] y;
        if (x > MAX32_W)
            y = 32'sh7FFF_FFFF;
        else if (x < MIN32_W)
            y = 32'sh8000_0000;
        else
            y = SAMPLE_W'(x);
        return y;
    endfunction

    // Control state.
    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [CHANNELS-1:0] seeded_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;

    // Configuration.
    logic [15:0] nf_a_reg;
    logic [14:0] dz_a_reg;
    logic [15:0] nf_b_reg;
    logic [14:0] dz_b_reg;
    logic [23:0] period_reg;

    // Channel store and request.
    entry_t           mem [CHANNELS];
    entry_t           rd_reg;
    item_t            in_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_in;

    // Datapath registers.
    logic [31:0]               w2_reg;
    logic [25:0]               c_reg;
    logic signed [STATE_W-1:0] a1_reg;
    logic signed [STATE_W-1:0] ka_reg;
    logic signed [STATE_W-1:0] kv_reg;
    logic signed [STATE_W-1:0] pp_reg;
    logic signed [STATE_W-1:0] p0_reg;
    logic signed [STATE_W-1:0] v0_reg;
    logic signed [SAMPLE_W-1:0] u0_reg;
    logic signed [SAMPLE_W-1:0] um_reg;
    logic signed [SUM_W-1:0]   sp_reg;
    logic signed [SUM_W-1:0]   sv_reg;
    logic signed [X_W-1:0]     r_reg;
    logic                      neg_reg;

    // Combinational signals.
    logic                      accept;
    logic                      seed;
    logic                      out_free;
    logic                      store_en;
    logic                      mul_start;
    logic                      div_start;
    op_t                       op;
    logic [15:0]               wn;
    logic [14:0]               zt;
    logic [COEF_W-1:0]         coef;
    logic signed [X_W-1:0]     x;
    logic [X_W-1:0]            x_mag;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      div_done;
    logic [X_W-1:0]            div_quot;
    logic                      gain_ovf;
    logic [X_W-1:0]            post_mag;
    logic signed [X_W-1:0]     r_post;
    logic [X_W-1:0]            div_in;
    logic signed [X_W-1:0]     base;
    logic signed [52:0]        wb_sum;
    logic signed [STATE_W-1:0] wb_sat;
    logic signed [32:0]        mid_sum;
    logic signed [32:0]        mid_adj;

    assign accept    = item_valid && item_ready;
    assign cfg_ready = 1'b1;
    assign op        = op_at(step_reg);
    assign wn        = in_reg.gain_select ? nf_b_reg : nf_a_reg;
    assign zt        = in_reg.gain_select ? dz_b_reg : dz_a_reg;
    assign seed      = in_reg.restart || !seeded_reg[idx_reg];
    assign out_free  = !result_valid_reg || result_ready;

    // Channel field folded onto the number of channels.
    always_comb
    begin
        logic [6:0] t;
        t = 7'(item.channel);
        for (int i = 0; i < 8; i++)
        begin
            if (t >= CH_L)
                t = t - CH_L;
        end
        idx_in = t[IDX_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_valid) state_next = ST_LOAD;
            ST_LOAD:  state_next = seed ? ST_STORE : ST_ISSUE;
            ST_ISSUE: state_next = ST_MUL;
            ST_MUL:   if (mul_done) state_next = ST_POST;
            ST_POST:  state_next = (op.scale == SC_SIXTH) ? ST_DIV : ST_WB;
            ST_DIV:   if (div_done) state_next = ST_WB;
            ST_WB:    state_next = (step_reg == STEP_W'(N_OPS - 1)) ? ST_STORE : ST_ISSUE;
            ST_STORE: if (out_free) state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        mul_start  = (state_reg == ST_ISSUE);
        div_start  = (state_reg == ST_POST) && (op.scale == SC_SIXTH);
        store_en   = (state_reg == ST_STORE) && out_free;
    end

    // Multiplier coefficient and operand.
    always_comb
    begin
        unique case (op.coef)
            CF_WN: coef = COEF_W'(wn);
            CF_W2: coef = w2_reg;
            CF_C:  coef = COEF_W'(c_reg);
            CF_T:  coef = COEF_W'(period_reg);
        endcase
        unique case (op.xsrc)
            XS_WN:    x = X_W'(signed'({1'b0, wn}));
            XS_ZT:    x = X_W'(signed'({1'b0, zt}));
            XS_U0_P0: x = X_W'(u0_reg) - X_W'(p0_reg);
            XS_UM_PP: x = X_W'(um_reg) - X_W'(pp_reg);
            XS_U1_PP: x = X_W'(in_reg.sample) - X_W'(pp_reg);
            XS_KV:    x = X_W'(kv_reg);
            XS_KA:    x = X_W'(ka_reg);
            XS_SP:    x = X_W'(sp_reg);
            XS_SV:    x = X_W'(sv_reg);
            default:  x = '0;
        endcase
        x_mag = x[X_W-1] ? X_W'(-x) : X_W'(x);
    end

    sovf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .coef    (coef),
        .mag     (x_mag),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Scaling of the product; magnitudes are truncated before the sign goes back.
    always_comb
    begin
        gain_ovf = (|mul_prod[PROD_W-1:63]) || ((&mul_prod[62:16]) && (|mul_prod[15:0]));
        div_in   = {1'b0, mul_prod[74:24]};
        post_mag = '0;
        unique case (op.scale)
            SC_RAW:   post_mag = mul_prod[X_W-1:0];
            SC_GAIN:  post_mag = X_W'(mul_prod[63:16]);
            SC_HALF:  post_mag = X_W'(mul_prod[74:25]);
            SC_FULL:  post_mag = X_W'(mul_prod[74:24]);
            SC_SIXTH: post_mag = '0;
            default:  post_mag = '0;
        endcase
        if (op.scale == SC_GAIN && gain_ovf)
            r_post = neg_reg ? X_W'(MIN48) : X_W'(MAX48);
        else
            r_post = neg_reg ? -signed'(post_mag) : signed'(post_mag);
    end

    sovf_div6 u_div6 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Write-back adder with saturation.
    always_comb
    begin
        unique case (op.dest)
            DS_KA:        base = X_W'(a1_reg);
            DS_PP, DS_P0: base = X_W'(p0_reg);
            DS_KV, DS_V0: base = X_W'(v0_reg);
            default:      base = '0;
        endcase
        if (op.dest == DS_KA)
            wb_sum = 53'(base) - 53'(r_reg);
        else
            wb_sum = 53'(base) + 53'(r_reg);
        wb_sat = sat48(wb_sum);
    end

    // Input midpoint, truncated toward zero.
    assign mid_sum = 33'(rd_reg.previous) + 33'(in_reg.sample);
    assign mid_adj = mid_sum + 33'(mid_sum[32]);

    assign result_valid_next = store_en ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            seeded_reg       <= '0;
            result_valid_reg <= 1'b0;
            nf_a_reg         <= 16'd12800;
            dz_a_reg         <= 15'd4915;
            nf_b_reg         <= 16'd12800;
            dz_b_reg         <= 15'd4915;
            period_reg       <= 24'd167772;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (state_reg == ST_LOAD)
                step_reg <= '0;
            else if (state_reg == ST_WB)
                step_reg <= step_reg + 1'b1;
            if (store_en)
                seeded_reg[idx_reg] <= 1'b1;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NATURAL_FREQ_A: nf_a_reg   <= cfg_data[15:0];
                    REG_DAMPING_A:      dz_a_reg   <= cfg_data[14:0];
                    REG_NATURAL_FREQ_B: nf_b_reg   <= cfg_data[15:0];
                    REG_DAMPING_B:      dz_b_reg   <= cfg_data[14:0];
                    REG_STEP_PERIOD:    period_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Channel store: read on acceptance, written back at the end of the request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= mem[idx_in];
            in_reg  <= item;
            idx_reg <= idx_in;
        end
        if (store_en)
        begin
            mem[idx_reg] <= '{p0_reg, v0_reg, in_reg.sample};
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            if (seed)
            begin
                p0_reg <= STATE_W'(in_reg.sample);
                v0_reg <= '0;
            end
            else
            begin
                p0_reg <= rd_reg.position;
                v0_reg <= rd_reg.velocity;
                kv_reg <= rd_reg.velocity;
                sp_reg <= SUM_W'(rd_reg.velocity);
                sv_reg <= '0;
                u0_reg <= rd_reg.previous;
                um_reg <= mid_adj[32:1];
            end
        end
        if (state_reg == ST_ISSUE)
            neg_reg <= x[X_W-1];
        if (state_reg == ST_POST && op.scale != SC_SIXTH)
            r_reg <= r_post;
        if (state_reg == ST_DIV && div_done)
            r_reg <= neg_reg ? -signed'(div_quot) : signed'(div_quot);
        if (state_reg == ST_WB)
        begin
            unique case (op.dest)
                DS_W2: w2_reg <= r_reg[31:0];
                DS_C:  c_reg  <= r_reg[30:5];
                DS_A1: a1_reg <= r_reg[STATE_W-1:0];
                DS_KA:
                begin
                    ka_reg <= wb_sat;
                    sv_reg <= sv_reg + SUM_W'(wb_sat);
                end
                DS_PP: pp_reg <= wb_sat;
                DS_KV:
                begin
                    kv_reg <= wb_sat;
                    sp_reg <= sp_reg + SUM_W'(wb_sat);
                end
                DS_P0: p0_reg <= wb_sat;
                DS_V0: v0_reg <= wb_sat;
            endcase
        end
        if (store_en)
        begin
            result_reg <= '{in_reg.channel, sat32(p0_reg), sat32(v0_reg)};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The shared units finish only while the sequencer waits on them.
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL)
        else $error("multiplier finished outside its wait state");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted request did not load channel state");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ISSUE |-> step_reg < STEP_W'(N_OPS))
        else $error("microcode step out of range");

    a_result_from_store: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_STORE)
        else $error("result raised without a store");

endmodule
